// ===== rtl/fmbq_pkg.sv =====
// shared types and constants for the front/middle/back queue
`timescale 1ns / 1ps

package fmbq_pkg;

    localparam int CAPACITY_DEF   = 16;
    localparam int DATA_WIDTH_DEF = 32;
    localparam int ACTION_W       = 3;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FRONT  = 3'd0,
        ACT_PUSH_MIDDLE = 3'd1,
        ACT_PUSH_BACK   = 3'd2,
        ACT_POP_FRONT   = 3'd3,
        ACT_POP_MIDDLE  = 3'd4,
        ACT_POP_BACK    = 3'd5
    } action_t;

    // per-cell load and pick controls driven by the top level
    typedef struct packed {
        logic take_new;
        logic take_left;
        logic take_right;
        logic pick;
    } cell_ctrl_t;

endpackage

// ===== rtl/fmbq_cell.sv =====
// one storage cell of the queue chain, shifts toward either neighbor
`timescale 1ns / 1ps

module fmbq_cell #(
    parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEF
) (
    input  logic                   clk,
    input  fmbq_pkg::cell_ctrl_t   ctrl,
    input  logic [DATA_WIDTH-1:0]  new_word,
    input  logic [DATA_WIDTH-1:0]  left_word,
    input  logic [DATA_WIDTH-1:0]  right_word,
    output logic [DATA_WIDTH-1:0]  word,
    output logic [DATA_WIDTH-1:0]  picked
);
    import fmbq_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    always_comb
    begin
        if (ctrl.take_new)
        begin
            data_next = new_word;
        end
        else if (ctrl.take_left)
        begin
            data_next = left_word;
        end
        else if (ctrl.take_right)
        begin
            data_next = right_word;
        end
        else
        begin
            data_next = data_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign word   = data_reg;
    assign picked = ctrl.pick ? data_reg : '0;

endmodule

// ===== rtl/front_middle_back_queue_unit.sv =====
// front/middle/back queue: a chain of shifting cells with a registered result beat
//
//  channel | dir | tdata (low bit up)             | tuser  | tlast
//  s_*     | in  | value                          | action | -
//  m_*     | out | removed_value, entry_count     | ok     | -
//
// one beat per cycle while not stalled: cells at or above pos shift when taken,
// the result is stored in the output register in that same edge
// a stalled result holds and blocks only the next input beat
// reset clears the count and the result valid; cell contents stay undefined
`timescale 1ns / 1ps

module front_middle_back_queue_unit #(
    parameter int CAPACITY   = fmbq_pkg::CAPACITY_DEF,
    parameter int DATA_WIDTH = fmbq_pkg::DATA_WIDTH_DEF,
    localparam int CNT_W     = $clog2(CAPACITY + 1),
    localparam int IN_W      = ((DATA_WIDTH + 7) / 8) * 8,
    localparam int OUT_W     = ((DATA_WIDTH + CNT_W + 7) / 8) * 8
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [IN_W-1:0]               s_tdata,   // value
    input  logic [fmbq_pkg::ACTION_W-1:0] s_tuser,   // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [OUT_W-1:0]              m_tdata,   // removed_value, entry_count
    output logic [0:0]                    m_tuser    // ok
);
    import fmbq_pkg::*;

    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]      count_reg;
    logic [CNT_W-1:0]      count_next;
    logic                  out_valid_reg;
    logic                  ok_reg;
    logic                  ok_next;
    logic [DATA_WIDTH-1:0] removed_reg;
    logic [DATA_WIDTH-1:0] removed_next;

    logic                  fire;
    logic                  is_push;
    logic                  is_pop;
    logic                  do_ins;
    logic                  do_rem;
    logic [CNT_W-1:0]      pos;
    logic [DATA_WIDTH-1:0] in_word;
    logic [DATA_WIDTH-1:0] picked_or;

    cell_ctrl_t            ctrl   [CAPACITY];
    logic [DATA_WIDTH-1:0] words  [CAPACITY];
    logic [DATA_WIDTH-1:0] picked [CAPACITY];

    assign s_tready = !out_valid_reg || m_tready;
    assign fire     = s_tvalid && s_tready;
    assign in_word  = s_tdata[DATA_WIDTH-1:0];

    always_comb
    begin
        is_push = 1'b0;
        is_pop  = 1'b0;
        pos     = '0;
        case (action_t'(s_tuser))
            ACT_PUSH_FRONT:
            begin
                is_push = 1'b1;
            end
            ACT_PUSH_MIDDLE:
            begin
                is_push = 1'b1;
                pos     = count_reg >> 1;
            end
            ACT_PUSH_BACK:
            begin
                is_push = 1'b1;
                pos     = count_reg;
            end
            ACT_POP_FRONT:
            begin
                is_pop = 1'b1;
            end
            ACT_POP_MIDDLE:
            begin
                is_pop = 1'b1;
                pos    = (count_reg - 1'b1) >> 1;
            end
            ACT_POP_BACK:
            begin
                is_pop = 1'b1;
                pos    = count_reg - 1'b1;
            end
            default:
            begin
                is_push = 1'b0;
            end
        endcase
    end

    assign do_ins = fire && is_push && (count_reg != CAP_CNT);
    assign do_rem = fire && is_pop && (count_reg != '0);

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic [CNT_W-1:0]      idx;
        logic [DATA_WIDTH-1:0] left_w;
        logic [DATA_WIDTH-1:0] right_w;

        assign idx = CNT_W'(i);
        assign ctrl[i].take_new   = do_ins && (idx == pos);
        assign ctrl[i].take_left  = do_ins && (idx > pos);
        assign ctrl[i].take_right = do_rem && (idx >= pos);
        assign ctrl[i].pick       = do_rem && (idx == pos);

        if (i == 0)
        begin : g_first
            assign left_w = in_word;
        end
        else
        begin : g_mid
            assign left_w = words[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_body
            assign right_w = words[i+1];
        end

        fmbq_cell #(
            .DATA_WIDTH (DATA_WIDTH)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl[i]),
            .new_word   (in_word),
            .left_word  (left_w),
            .right_word (right_w),
            .word       (words[i]),
            .picked     (picked[i])
        );
    end

    always_comb
    begin
        picked_or = '0;
        for (int i = 0; i < CAPACITY; i++)
        begin
            picked_or = picked_or | picked[i];
        end
    end

    always_comb
    begin
        count_next   = count_reg;
        ok_next      = ok_reg;
        removed_next = removed_reg;
        if (fire)
        begin
            ok_next      = do_ins || do_rem;
            removed_next = picked_or;
            if (do_ins)
            begin
                count_next = count_reg + 1'b1;
            end
            else if (do_rem)
            begin
                count_next = count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        ok_reg      <= ok_next;
        removed_reg <= removed_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = ok_reg;
    assign m_tdata  = OUT_W'({count_reg, removed_reg});

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CAP_CNT)
        else $error("count above capacity");

    a_push_grows: assert property (@(posedge clk) disable iff (!rst_n)
        do_ins |=> (count_reg == $past(count_reg) + 1'b1) && m_tvalid && m_tuser[0])
        else $error("push did not grow count");

    a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser[0]) |-> (removed_reg == '0))
        else $error("failed beat carries a word");

    a_empty_pop: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && is_pop && count_reg == '0) |=> (m_tvalid && !m_tuser[0] && count_reg == '0))
        else $error("pop from empty not refused");

endmodule
